### rtl/core/oukt_pkg.sv
package oukt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_BITS    = 16;

    // field widths of the command and result items
    localparam int OP_W     = 3;
    localparam int KEY_F_W  = 16;
    localparam int VAL_W    = 8;
    localparam int POS_W    = 8;
    localparam int STAT_W   = 3;
    localparam int COUNT_W  = 6;

    // internal widths
    localparam int KEY_W = (KEY_BITS < KEY_F_W) ? KEY_BITS : KEY_F_W;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_RD_FRT = 3'd2;
    localparam logic [OP_W-1:0] OP_RD_BCK = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [KEY_F_W-1:0] key;
        logic [VAL_W-1:0]   value;
        logic [POS_W-1:0]   position;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [KEY_F_W-1:0] out_key;
        logic [VAL_W-1:0]   out_value;
        logic [COUNT_W-1:0] entry_count;
        logic               last;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic dump_step;
    } dp_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic dump_more;
    } dp_stat_t;

endpackage

### rtl/core/oukt_ctrl.sv
module oukt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  oukt_pkg::dp_stat_t stat,
    output oukt_pkg::dp_ctrl_t ctrl,
    output logic              busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DUMP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC, S_DUMP:
            begin
                state_next = stat.dump_more ? S_DUMP : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign ctrl.load      = (state_reg == S_IDLE) && start;
    assign ctrl.exec      = (state_reg == S_EXEC);
    assign ctrl.dump_step = (state_reg == S_DUMP);
    assign busy           = (state_reg != S_IDLE);

    // an accepted item always gets exactly one execute cycle next
    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> (state_reg == S_EXEC))
        else $error("load not followed by execute");

    // dump walk only follows execute or itself
    a_dump_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_DUMP) |-> $past(state_reg == S_EXEC))
        else $error("dump entered from wrong state");

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");

endmodule

### rtl/core/oukt_datapath.sv
module oukt_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  oukt_pkg::cmd_t     cmd,
    input  oukt_pkg::dp_ctrl_t ctrl,
    output oukt_pkg::dp_stat_t stat,
    output oukt_pkg::result_t  result,
    output logic               result_valid
);

    localparam int DEPTH = oukt_pkg::TABLE_DEPTH;
    localparam int KW    = oukt_pkg::KEY_W;
    localparam int IW    = oukt_pkg::IDX_W;
    localparam int CW    = oukt_pkg::CNT_W;
    localparam int PW    = oukt_pkg::CMP_W;
    localparam int VW    = oukt_pkg::VAL_W;

    oukt_pkg::cmd_t    cmd_reg;
    oukt_pkg::result_t result_reg;
    oukt_pkg::result_t result_next;
    logic              valid_reg;
    logic [CW-1:0]     fill_reg;
    logic [CW-1:0]     fill_next;
    logic [IW-1:0]     dump_idx_reg;
    logic [KW-1:0]     keys_reg [DEPTH];
    logic [VW-1:0]     vals_reg [DEPTH];

    logic [KW-1:0]     key_m;
    logic [DEPTH-1:0]  match;
    logic              hit;
    logic [IW-1:0]     slot;
    logic [DEPTH-1:0]  shift_sel;
    logic              append_we;
    logic              shift_en;
    logic [IW-1:0]     cur_idx;
    logic [IW-1:0]     rd_idx;
    logic [PW-1:0]     pos_x;
    logic [PW-1:0]     fill_x;
    logic [PW-1:0]     slot_frt;
    logic [PW-1:0]     slot_bck;
    logic              pos_bad;
    logic              is_read;
    logic              dump_more;
    logic [KW-1:0]     rd_key;
    logic [VW-1:0]     rd_val;

    assign key_m = cmd_reg.key[KW-1:0];

    // all cells compare at once; keys are unique so at most one hits
    always_comb
    begin
        slot = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i] = (CW'(i) < fill_reg) && (keys_reg[i] == key_m);
            if (match[i])
            begin
                slot = slot | IW'(i);
            end
        end
        hit = |match;
        for (int i = 0; i < DEPTH; i++)
        begin
            shift_sel[i] = (IW'(i) >= slot);
        end
    end

    // read address: position lookup or dump walk
    assign pos_x    = PW'(cmd_reg.position);
    assign fill_x   = PW'(fill_reg);
    assign slot_frt = pos_x - PW'(1);
    assign slot_bck = fill_x - pos_x;
    assign pos_bad  = (cmd_reg.position == '0) || (pos_x > fill_x);
    assign is_read  = (cmd_reg.operation == oukt_pkg::OP_RD_FRT) ||
                      (cmd_reg.operation == oukt_pkg::OP_RD_BCK);
    assign cur_idx  = ctrl.exec ? '0 : dump_idx_reg;

    always_comb
    begin
        if (is_read)
        begin
            rd_idx = (cmd_reg.operation == oukt_pkg::OP_RD_FRT) ? slot_frt[IW-1:0]
                                                                : slot_bck[IW-1:0];
        end
        else
        begin
            rd_idx = cur_idx;
        end
    end

    assign rd_key = keys_reg[rd_idx];
    assign rd_val = vals_reg[rd_idx];

    assign dump_more = (cmd_reg.operation == oukt_pkg::OP_DUMP) &&
                       ((CW'(cur_idx) + CW'(1)) < fill_reg);
    assign stat.dump_more = dump_more;

    always_comb
    begin
        result_next = '0;
        result_next.status = oukt_pkg::ST_NOTFOUND;
        result_next.last   = 1'b1;
        fill_next = fill_reg;
        append_we = 1'b0;
        shift_en  = 1'b0;
        if (ctrl.exec)
        begin
            unique case (cmd_reg.operation)
                oukt_pkg::OP_APPEND:
                begin
                    if (hit)
                    begin
                        result_next.status = oukt_pkg::ST_DUP;
                    end
                    else if (fill_reg >= CW'(DEPTH))
                    begin
                        result_next.status = oukt_pkg::ST_FULL;
                    end
                    else
                    begin
                        result_next.status = oukt_pkg::ST_OK;
                        append_we = 1'b1;
                        fill_next = fill_reg + CW'(1);
                    end
                end
                oukt_pkg::OP_DELETE:
                begin
                    if (fill_reg == '0)
                    begin
                        result_next.status = oukt_pkg::ST_EMPTY;
                    end
                    else if (hit)
                    begin
                        result_next.status = oukt_pkg::ST_OK;
                        shift_en  = 1'b1;
                        fill_next = fill_reg - CW'(1);
                    end
                end
                oukt_pkg::OP_RD_FRT, oukt_pkg::OP_RD_BCK:
                begin
                    if (fill_reg == '0)
                    begin
                        result_next.status = oukt_pkg::ST_EMPTY;
                    end
                    else if (!pos_bad)
                    begin
                        result_next.status    = oukt_pkg::ST_OK;
                        result_next.out_key   = oukt_pkg::KEY_F_W'(rd_key);
                        result_next.out_value = rd_val;
                    end
                end
                oukt_pkg::OP_DUMP:
                begin
                    if (fill_reg == '0)
                    begin
                        result_next.status = oukt_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        result_next.status    = oukt_pkg::ST_OK;
                        result_next.out_key   = oukt_pkg::KEY_F_W'(rd_key);
                        result_next.out_value = rd_val;
                        result_next.last      = !dump_more;
                    end
                end
                oukt_pkg::OP_CLEAR:
                begin
                    if (fill_reg == '0)
                    begin
                        result_next.status = oukt_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        result_next.status = oukt_pkg::ST_OK;
                        fill_next = '0;
                    end
                end
                default:
                begin
                    result_next.status = oukt_pkg::ST_NOTFOUND;
                end
            endcase
        end
        else
        begin
            result_next.status    = oukt_pkg::ST_OK;
            result_next.out_key   = oukt_pkg::KEY_F_W'(rd_key);
            result_next.out_value = rd_val;
            result_next.last      = !dump_more;
        end
        result_next.entry_count = oukt_pkg::COUNT_W'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            valid_reg    <= 1'b0;
            dump_idx_reg <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            valid_reg <= ctrl.exec || ctrl.dump_step;
            if (ctrl.exec || ctrl.dump_step)
            begin
                dump_idx_reg <= cur_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
        end
        if (ctrl.exec || ctrl.dump_step)
        begin
            result_reg <= result_next;
        end
    end

    // record cells: write at the back on append, pull from the next cell on delete
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (append_we && (fill_reg[IW-1:0] == IW'(g)))
            begin
                keys_reg[g] <= key_m;
                vals_reg[g] <= cmd_reg.value;
            end
            else if (shift_en && shift_sel[g])
            begin
                if (g < DEPTH - 1)
                begin
                    keys_reg[g] <= keys_reg[(g + 1) % DEPTH];
                    vals_reg[g] <= vals_reg[(g + 1) % DEPTH];
                end
            end
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count above table depth");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (result_reg.entry_count == oukt_pkg::COUNT_W'(fill_reg)))
        else $error("reported count differs from table");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.exec && (cmd_reg.operation == oukt_pkg::OP_CLEAR)) |=> (fill_reg == '0))
        else $error("clear left records");

    a_dump_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result_reg.last) |=> valid_reg)
        else $error("dump stopped before last marker");

endmodule

### rtl/core/ordered_unique_key_table.sv
// Ordered unique-key table: up to oukt_pkg::TABLE_DEPTH records (key, value)
// kept in insertion order. Drive cmd with start high while busy is low; the
// item is taken on that edge. Every result appears on result for exactly one
// cycle with result_valid high and cannot be held off, so capture it then.
// Append, delete, reads, clear and unused codes give a single result, taken
// into the result register at the end of the execute state, and busy drops in
// the cycle the result is shown, so a new item may be issued then. A dump of
// N records gives N results on consecutive cycles, last set on the final one;
// on an empty table it gives a single empty result. The datapath latches
// the item on acceptance, then runs an execute state in which every record
// cell compares its key in parallel and a delete shifts the later cells
// forward, and for a dump a walk reading one record per cycle through the
// shared read port. entry_count on every result is the record count after the
// operation. Reset empties the table; no clearing pass is needed.
module ordered_unique_key_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  oukt_pkg::cmd_t    cmd,
    output oukt_pkg::result_t result,
    output logic              result_valid
);

    oukt_pkg::dp_ctrl_t ctrl;
    oukt_pkg::dp_stat_t stat;

    // sequencer: idle / execute / dump walk
    oukt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // record cells, lookup, read port and result register
    oukt_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .ctrl         (ctrl),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import oukt_pkg::*;

    // codes the block does not define; both must answer not found
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam int POOL_SIZE    = 40;   // more keys than slots, so the table can fill
    localparam int STALL_LIMIT  = 400;  // quiet stretch the watchdog allows before it fails the run
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 65;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    start        = 1'b0;
    cmd_t    cmd          = '0;
    logic    busy;
    result_t result;
    logic    result_valid;

    ordered_unique_key_table DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result       (result),
        .result_valid (result_valid)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the table, front record at index 0
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] tbl_keys [TABLE_DEPTH];
    logic [VAL_W-1:0] tbl_vals [TABLE_DEPTH];
    int               tbl_fill = 0;

    result_t expected_results [$];   // table answers still owed by the block
    cmd_t    pending_cmds [$];       // items not yet put on the bus
    logic [KEY_F_W-1:0] key_pool [POOL_SIZE];

    int   items_queued = 0;
    int   items_taken  = 0;
    int   fail_count   = 0;
    int   gap_left     = 0;
    int   quiet_cycles = 0;
    logic took_item    = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Table behavior
    // ------------------------------------------------------------------
    function automatic void push_answer(logic [STAT_W-1:0] st, logic [KEY_W-1:0] k,
                                        logic [VAL_W-1:0] v, logic lst);
        result_t r;
        r.status      = st;
        r.out_key     = KEY_F_W'(k);
        r.out_value   = v;
        r.entry_count = COUNT_W'(tbl_fill);   // count after the operation
        r.last        = lst;
        expected_results.push_back(r);
    endfunction

    function automatic int find_slot(logic [KEY_W-1:0] k);
        for (int i = 0; i < tbl_fill; i++)
            if (tbl_keys[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void apply_table_op(cmd_t c);
        logic [KEY_W-1:0] k;
        int               slot;
        k = c.key[KEY_W-1:0];
        slot = find_slot(k);
        case (c.operation)
            OP_APPEND:
            begin
                // duplicate check wins over full check
                if (slot >= 0)
                    push_answer(ST_DUP, '0, '0, 1'b1);
                else if (tbl_fill >= TABLE_DEPTH)
                    push_answer(ST_FULL, '0, '0, 1'b1);
                else
                begin
                    tbl_keys[tbl_fill] = k;
                    tbl_vals[tbl_fill] = c.value;
                    tbl_fill++;
                    push_answer(ST_OK, '0, '0, 1'b1);
                end
            end
            OP_DELETE:
            begin
                if (tbl_fill == 0)
                    push_answer(ST_EMPTY, '0, '0, 1'b1);
                else if (slot < 0)
                    push_answer(ST_NOTFOUND, '0, '0, 1'b1);
                else
                begin
                    // later records close the gap
                    for (int i = slot; i < tbl_fill - 1; i++)
                    begin
                        tbl_keys[i] = tbl_keys[i + 1];
                        tbl_vals[i] = tbl_vals[i + 1];
                    end
                    tbl_fill--;
                    push_answer(ST_OK, '0, '0, 1'b1);
                end
            end
            OP_RD_FRT, OP_RD_BCK:
            begin
                if (tbl_fill == 0)
                    push_answer(ST_EMPTY, '0, '0, 1'b1);
                else if (c.position == 0 || int'(c.position) > tbl_fill)
                    push_answer(ST_NOTFOUND, '0, '0, 1'b1);
                else
                begin
                    slot = (c.operation == OP_RD_FRT) ? int'(c.position) - 1
                                                      : tbl_fill - int'(c.position);
                    push_answer(ST_OK, tbl_keys[slot], tbl_vals[slot], 1'b1);
                end
            end
            OP_DUMP:
            begin
                if (tbl_fill == 0)
                    push_answer(ST_EMPTY, '0, '0, 1'b1);
                else
                    for (int i = 0; i < tbl_fill; i++)
                        push_answer(ST_OK, tbl_keys[i], tbl_vals[i], i == tbl_fill - 1);
            end
            OP_CLEAR:
            begin
                if (tbl_fill == 0)
                    push_answer(ST_EMPTY, '0, '0, 1'b1);
                else
                begin
                    tbl_fill = 0;
                    push_answer(ST_OK, '0, '0, 1'b1);
                end
            end
            default:
                push_answer(ST_NOTFOUND, '0, '0, 1'b1);
        endcase
    endfunction

    task automatic check_answer(result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: unexpected result: st=%0d key=%h val=%h cnt=%0d last=%b",
                         $realtime, got.status, got.out_key, got.out_value,
                         got.entry_count, got.last);
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.status !== want.status || got.out_key !== want.out_key ||
                got.out_value !== want.out_value || got.entry_count !== want.entry_count ||
                got.last !== want.last)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("%0t: mismatch: expected st=%0d key=%h val=%h cnt=%0d last=%b",
                             $realtime, want.status, want.out_key, want.out_value,
                             want.entry_count, want.last);
                    $display("    got st=%0d key=%h val=%h cnt=%0d last=%b",
                             got.status, got.out_key, got.out_value,
                             got.entry_count, got.last);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic queue_cmd(logic [OP_W-1:0] op, logic [KEY_F_W-1:0] k,
                             logic [VAL_W-1:0] v, logic [POS_W-1:0] p);
        cmd_t c;
        c.operation = op;
        c.key       = k;
        c.value     = v;
        c.position  = p;
        pending_cmds.push_back(c);
        items_queued++;
    endtask

    // mostly pool keys so appends collide and deletes hit; some wild keys
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            c.operation = OP_APPEND;
        else if (pick < 55)
            c.operation = OP_DELETE;
        else if (pick < 70)
            c.operation = OP_RD_FRT;
        else if (pick < 85)
            c.operation = OP_RD_BCK;
        else if (pick < 93)
            c.operation = OP_DUMP;
        else if (pick < 97)
            c.operation = OP_CLEAR;
        else
            c.operation = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
        if ($urandom_range(0, 7) == 0)
            c.key = KEY_F_W'($urandom);
        else
            c.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        c.value = VAL_W'($urandom);
        if ($urandom_range(0, 9) == 0)
            c.position = POS_W'($urandom);
        else
            c.position = POS_W'($urandom_range(0, TABLE_DEPTH + 2));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Driver: new item on the falling edge once the last one was taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic nxt_start;
        cmd_t nxt_cmd;
        nxt_start = start;
        nxt_cmd   = cmd;
        if (rst_n && (!start || took_item))
        begin
            nxt_start = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_cmds.size() > 0)
            begin
                nxt_cmd   = pending_cmds.pop_front();
                nxt_start = 1'b1;
                // idle bursts after some items; none in the tail of the run
                if (pending_cmds.size() > 24 && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 6);
            end
        end
        start <= nxt_start;
        cmd   <= nxt_cmd;
    end

    // ------------------------------------------------------------------
    // Monitor: take items and results on the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        took_item <= rst_n && start && !busy;
        if (rst_n && start && !busy)
        begin
            apply_table_op(cmd);
            items_taken++;
        end
        if (rst_n && result_valid)
            check_answer(result);
    end

    // watchdog: quiet means no item and no result moved
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        // low six bits make every pool key distinct
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {(KEY_F_W - 6)'($urandom), 6'(i)};

        // empty-table corners
        queue_cmd(OP_DUMP,    16'h0000, 8'h00, 8'd0);
        queue_cmd(OP_RD_FRT,  16'h0000, 8'h00, 8'd1);
        queue_cmd(OP_RD_BCK,  16'hFFFF, 8'hFF, 8'd255);
        queue_cmd(OP_DELETE,  16'h0000, 8'h00, 8'd0);
        queue_cmd(OP_CLEAR,   16'h0000, 8'h00, 8'd0);
        queue_cmd(OP_SPARE_A, 16'hFFFF, 8'hFF, 8'd255);
        // extreme keys and values, duplicate rejected
        queue_cmd(OP_APPEND,  16'h0000, 8'h00, 8'd0);
        queue_cmd(OP_APPEND,  16'hFFFF, 8'hFF, 8'd255);
        queue_cmd(OP_APPEND,  16'h0000, 8'h33, 8'd0);
        queue_cmd(OP_APPEND,  16'h1234, 8'h5A, 8'd0);
        // reads: position zero, beyond count, both ends
        queue_cmd(OP_RD_FRT,  16'h0000, 8'h00, 8'd0);
        queue_cmd(OP_RD_FRT,  16'h0000, 8'h00, 8'd255);
        queue_cmd(OP_RD_FRT,  16'h0000, 8'h00, 8'd1);
        queue_cmd(OP_RD_BCK,  16'h0000, 8'h00, 8'd1);
        queue_cmd(OP_RD_BCK,  16'h0000, 8'h00, 8'd3);
        queue_cmd(OP_RD_FRT,  16'h0000, 8'h00, 8'd4);
        // absent key, then middle delete so the back record moves up
        queue_cmd(OP_DELETE,  16'h4321, 8'h00, 8'd0);
        queue_cmd(OP_DELETE,  16'hFFFF, 8'h00, 8'd0);
        queue_cmd(OP_DUMP,    16'h0000, 8'h00, 8'd0);
        queue_cmd(OP_SPARE_B, 16'h0000, 8'h00, 8'd0);
        queue_cmd(OP_CLEAR,   16'h0000, 8'h00, 8'd0);
        queue_cmd(OP_DUMP,    16'h0000, 8'h00, 8'd0);

        // fill to capacity, overflow, duplicate while full, full dump
        queue_cmd(OP_CLEAR, 16'h0000, 8'h00, 8'd0);
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
            queue_cmd(OP_APPEND, key_pool[i], VAL_W'($urandom), POS_W'($urandom));
        queue_cmd(OP_APPEND, key_pool[0], VAL_W'($urandom), 8'd0);
        queue_cmd(OP_DUMP,   16'h0000, 8'h00, 8'd0);
        queue_cmd(OP_RD_BCK, 16'h0000, 8'h00, POS_W'(TABLE_DEPTH));
        queue_cmd(OP_RD_FRT, 16'h0000, 8'h00, POS_W'(TABLE_DEPTH));
        queue_cmd(OP_RD_FRT, 16'h0000, 8'h00, POS_W'(TABLE_DEPTH + 1));
        queue_cmd(OP_DELETE, key_pool[0], 8'h00, 8'd0);
        queue_cmd(OP_DELETE, key_pool[TABLE_DEPTH - 1], 8'h00, 8'd0);
        queue_cmd(OP_DUMP,   16'h0000, 8'h00, 8'd0);

        // random mix on a partly full table
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_cmds.push_back(random_cmd());
        items_queued += RANDOM_ITEMS;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // counters and queues only move on rising edges; poll on falling ones
        while (items_taken < items_queued)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### ordered_unique_key_table.f
rtl/core/oukt_pkg.sv
rtl/core/oukt_ctrl.sv
rtl/core/oukt_datapath.sv
rtl/core/ordered_unique_key_table.sv
dv/tb.sv
